@@ rtl/fdcd_pkg.sv @@
// ----------------------------------------------------------------------------
// fdcd_pkg
// Shared sizes, types and constants of the FSK delay-line correlator
// demodulator.
// ----------------------------------------------------------------------------
package fdcd_pkg;

	localparam int SAMPLE_BITS = 10;
	localparam int DELAY_TAPS  = 12;
	localparam int RING_LEN    = 12;

	localparam int HIST_W   = DELAY_TAPS + 1;
	localparam int PTR_W    = $clog2(RING_LEN);
	localparam int SUM_W    = 4;
	localparam int THRESH_W = 4;
	localparam int DUTY_W   = 8;
	localparam int DIV_W    = 8;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [SUM_W-1:0]       sum_t;
	typedef logic [THRESH_W-1:0]    thresh_t;
	typedef logic [DUTY_W-1:0]      duty_t;
	typedef logic [PTR_W-1:0]       ptr_t;

	localparam sample_t BIAS_RESET   = sample_t'(1) << (SAMPLE_BITS - 1);
	localparam thresh_t THRESH_RESET = thresh_t'(6);
	localparam duty_t   DUTY_OFFSET  = duty_t'(128);
	localparam ptr_t    PTR_LAST     = ptr_t'(RING_LEN - 1);

endpackage

@@ rtl/fsk_delay_correlator_demod_core.sv @@
// ----------------------------------------------------------------------------
// fsk_delay_correlator_demod_core
// Takes one converter sample per cycle while sample_stall is low and gives one
// demodulated result per sample: data bit, correlator sum and monitor PWM duty.
// ----------------------------------------------------------------------------
// Throughput is one sample per clock cycle while the result is not stalled; an
// accepted sample passes the input register and then the result register, around
// the single pass of bias tracking, slicing, correlation and window sum. A stalled
// result holds; the input register still takes one more sample behind it. The
// decision threshold resets to 6 and is written through the cfg channel, which is
// always ready.
module fsk_delay_correlator_demod_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  fdcd_pkg::sample_t  sample,
	output logic               result_valid,
	input  logic               result_stall,
	output logic               data_bit,
	output fdcd_pkg::sum_t     correlator_sum,
	output fdcd_pkg::duty_t    pwm_duty,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  fdcd_pkg::thresh_t  decision_threshold
);
	import fdcd_pkg::*;

	thresh_t thresh_q;
	logic    valid_s1;
	sample_t sample_s1;
	logic    advance;
	logic    xor_bit;
	sum_t    sum_next;

	assign cfg_ready    = 1'b1;
	assign advance      = valid_s1 && (!result_valid || !result_stall);
	assign sample_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			thresh_q <= THRESH_RESET;
		else if (cfg_valid && cfg_ready)
			thresh_q <= decision_threshold;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall)
			sample_s1 <= sample;
	end

	fdcd_slicer u_slicer (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.sample  (sample_s1),
		.xor_bit (xor_bit)
	);

	fdcd_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.xor_bit  (xor_bit),
		.sum_next (sum_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_bit       <= (sum_next < thresh_q);
			correlator_sum <= sum_next;
			pwm_duty       <= (duty_t'(sum_next) << 3) + DUTY_OFFSET;
		end
	end

	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (correlator_sum <= sum_t'(RING_LEN - 1)))
		else $error("correlator sum out of range");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (valid_s1 && result_valid && result_stall))
		else $error("input stalled without a blocked result");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid)
		else $error("advanced transaction did not reach the result register");

endmodule

@@ rtl/fdcd_slicer.sv @@
// ----------------------------------------------------------------------------
// fdcd_slicer
// Tracks the DC bias, slices the sample against it and correlates the slice
// with the slice from DELAY_TAPS samples earlier.
// ----------------------------------------------------------------------------
module fdcd_slicer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  fdcd_pkg::sample_t sample,
	output logic             xor_bit
);
	import fdcd_pkg::*;

	sample_t             bias_q;
	logic [DIV_W-1:0]    div_q;
	logic [HIST_W-1:0]   hist_q;
	sample_t             bias_next;
	logic                slice;

	always_comb begin
		bias_next = bias_q;
		if (div_q == '0) begin
			if (sample > bias_q)
				bias_next = bias_q + sample_t'(1);
			else if (sample < bias_q)
				bias_next = bias_q - sample_t'(1);
		end
		slice   = (sample > bias_next);
		xor_bit = slice ^ hist_q[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= BIAS_RESET;
			div_q  <= '0;
			hist_q <= '0;
		end else if (step) begin
			bias_q <= bias_next;
			div_q  <= div_q + DIV_W'(1);
			hist_q <= {slice, hist_q[HIST_W-1:1]};
		end
	end

endmodule

@@ rtl/fdcd_window.sv @@
// ----------------------------------------------------------------------------
// fdcd_window
// Ring of correlator bits with a running window sum.
// ----------------------------------------------------------------------------
module fdcd_window (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic          xor_bit,
	output fdcd_pkg::sum_t sum_next
);
	import fdcd_pkg::*;

	logic [RING_LEN-1:0] ring_q;
	ptr_t                ptr_q;
	sum_t                sum_q;
	ptr_t                ptr_next;

	always_comb begin
		ptr_next = (ptr_q == PTR_LAST) ? '0 : ptr_q + ptr_t'(1);
		sum_next = sum_q + sum_t'(xor_bit) - sum_t'(ring_q[ptr_next]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q <= '0;
			ptr_q  <= '0;
			sum_q  <= '0;
		end else if (step) begin
			ring_q[ptr_q] <= xor_bit;
			ptr_q         <= ptr_next;
			sum_q         <= sum_next;
		end
	end

endmodule

@@ bench/fsk_delay_correlator_demod_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsk_delay_correlator_demod_core_test
// Drives converter samples through the FSK delay-line demodulator with random
// gaps and result stalls, mirrors bias tracking, slicing, the delay-line XOR
// and the window sum, and checks every result field in order. The decision
// threshold is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module fsk_delay_correlator_demod_core_test;

	import fdcd_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PHASE_ITEMS = 150;
	localparam int LATENCY     = 2;
	localparam int N_PHASES    = 9;

	typedef struct packed {
		logic  data_bit;
		sum_t  sum;
		duty_t duty;
	} decision_t;

	typedef struct {
		sample_t   smp;
		bit        typed;
		decision_t want;
	} stim_row_t;

	logic    clk;
	logic    arst_n;
	logic    sample_valid;
	logic    sample_stall;
	sample_t sample;
	logic    result_valid;
	logic    result_stall;
	logic    data_bit;
	sum_t    correlator_sum;
	duty_t   pwm_duty;
	logic    cfg_valid;
	logic    cfg_ready;
	thresh_t decision_threshold;

	// demodulator state mirror
	sample_t                trk_bias   = BIAS_RESET;
	logic [DIV_W-1:0]       trk_div    = '0;
	logic [HIST_W-1:0]      slice_hist = '0;
	logic [RING_LEN-1:0]    xor_taps   = '0;
	int                     tap_ptr    = 0;
	int                     win_sum    = 0;
	thresh_t                thresh_now = THRESH_RESET;

	decision_t decisions_due[$];
	decision_t head;
	int        errors      = 0;
	int        cycle_count = 0;

	localparam thresh_t PHASE_THRESH [N_PHASES] = '{
		4'd0, 4'd15, 4'd12, 4'd1, 4'd13, 4'd6, 4'd11, 4'd14, 4'd3
	};

	stim_row_t directed_rows [20] = '{
		'{10'd1023, 1'b1, '{1'b1, 4'd1, 8'd136}},
		'{10'd0,    1'b1, '{1'b1, 4'd1, 8'd136}},
		'{10'd1023, 1'b1, '{1'b1, 4'd2, 8'd144}},
		'{10'd0,    1'b0, '0},
		'{10'd512,  1'b0, '0},
		'{10'd513,  1'b0, '0},
		'{10'd514,  1'b0, '0},
		'{10'd511,  1'b0, '0},
		'{10'd1,    1'b0, '0},
		'{10'd1022, 1'b0, '0},
		'{10'd1023, 1'b0, '0},
		'{10'd1023, 1'b0, '0},
		'{10'd0,    1'b0, '0},
		'{10'd0,    1'b0, '0},
		'{10'd1023, 1'b0, '0},
		'{10'd682,  1'b0, '0},
		'{10'd341,  1'b0, '0},
		'{10'd1023, 1'b0, '0},
		'{10'd0,    1'b0, '0},
		'{10'd1023, 1'b0, '0}
	};

	fsk_delay_correlator_demod_core dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.sample_valid       (sample_valid),
		.sample_stall       (sample_stall),
		.sample             (sample),
		.result_valid       (result_valid),
		.result_stall       (result_stall),
		.data_bit           (data_bit),
		.correlator_sum     (correlator_sum),
		.pwm_duty           (pwm_duty),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.decision_threshold (decision_threshold)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic decision_t demodulate_sample(sample_t v);
		logic      w;
		logic      m;
		int        nxt;
		decision_t d;
		if (trk_div == '0) begin
			if (v > trk_bias)
				trk_bias = trk_bias + 1'b1;
			else if (v < trk_bias)
				trk_bias = trk_bias - 1'b1;
		end
		trk_div = trk_div + 1'b1;
		w = (v > trk_bias);
		slice_hist = {w, slice_hist[HIST_W-1:1]};
		m = w ^ slice_hist[0];
		nxt = (tap_ptr + 1) % RING_LEN;
		xor_taps[tap_ptr] = m;
		win_sum = win_sum + int'(m) - int'(xor_taps[nxt]);
		tap_ptr = nxt;
		d.sum = sum_t'(win_sum);
		d.data_bit = (win_sum < int'(thresh_now));
		d.duty = duty_t'(win_sum * 8 + int'(DUTY_OFFSET));
		return d;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// entered and left at a falling edge
	task automatic offer_sample(input sample_t v, input bit idle, input bit typed,
			input decision_t want);
		int        n;
		decision_t got;
		n = idle ? pick_gap() : 0;
		repeat (n) begin
			sample_valid = 1'b0;
			sample = sample_t'($urandom);
			@(negedge clk);
		end
		sample_valid = 1'b1;
		sample = v;
		do
			@(posedge clk);
		while (sample_stall);
		got = demodulate_sample(v);
		decisions_due.push_back(typed ? want : got);
		@(negedge clk);
	endtask

	task automatic set_threshold(input thresh_t t);
		cfg_valid = 1'b1;
		decision_threshold = t;
		do
			@(posedge clk);
		while (!cfg_ready);
		thresh_now = t;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic run_phase(input thresh_t t, input int items, input bit idle);
		int      k;
		int      i;
		int      r;
		int      seg;
		int      half;
		int      amp;
		int      ph;
		sample_t v;
		// drain before the register write
		sample_valid = 1'b0;
		wait (decisions_due.size() == 0);
		@(negedge clk);
		repeat (LATENCY + 2) @(negedge clk);
		set_threshold(t);
		k = 0;
		while (k < items) begin
			r = $urandom_range(0, 9);
			seg = $urandom_range(8, 64);
			half = (r < 3) ? 6 : (r < 6) ? 12 : $urandom_range(1, 16);
			amp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 511);
			ph = $urandom_range(0, 2 * half - 1);
			for (i = 0; i < seg && k < items; i++) begin
				if (r == 8)
					v = sample_t'($urandom);
				else if (r == 9)
					v = $urandom_range(0, 1) ? '1 : '0;
				else if (((i + ph) / half) % 2)
					v = sample_t'(512 + amp);
				else
					v = sample_t'(512 - amp);
				offer_sample(v, idle, 1'b0, '0);
				k++;
			end
		end
	endtask

	initial begin
		int n;
		int run;
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			result_stall = 1'b0;
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
			repeat (run) @(negedge clk);
			n = pick_gap();
			if (n > 0) begin
				result_stall = 1'b1;
				repeat (n) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (decisions_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: data_bit %0b sum %0d duty %0d",
					$time, data_bit, correlator_sum, pwm_duty);
			end else begin
				head = decisions_due.pop_front();
				if (data_bit !== head.data_bit) begin
					errors++;
					$display("%0t: data_bit expected %0b, got %0b",
						$time, head.data_bit, data_bit);
				end
				if (correlator_sum !== head.sum) begin
					errors++;
					$display("%0t: correlator_sum expected %0d, got %0d",
						$time, head.sum, correlator_sum);
				end
				if (pwm_duty !== head.duty) begin
					errors++;
					$display("%0t: pwm_duty expected %0d, got %0d",
						$time, head.duty, pwm_duty);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int p;
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		cfg_valid = 1'b0;
		decision_threshold = THRESH_RESET;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (directed_rows[i])
			offer_sample(directed_rows[i].smp, 1'b1, directed_rows[i].typed,
				directed_rows[i].want);
		for (p = 0; p < N_PHASES; p++)
			run_phase(PHASE_THRESH[p], PHASE_ITEMS, (p % 3) != 1);
		sample_valid = 1'b0;
		wait (decisions_due.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
